// File: design/snd_pkg.sv
// ----------------------------------------------------------------------------
// Sorted neighbor distances package
// Shared constants and types for the sorted neighbor distance block.
// ----------------------------------------------------------------------------
`default_nettype none
package snd_pkg;
    localparam int MAX_KEPT    = 16;
    localparam int NUM_SPECIES = 4;
    localparam int KEPT_W      = $clog2(MAX_KEPT);
    localparam int SPEC_W      = 2;
    localparam int CNT_W       = $clog2(MAX_KEPT + 1);

    localparam logic [1:0] REG_SEPARATE = 2'd0;
    localparam logic [1:0] REG_NEIGHBOR = 2'd1;
    localparam logic [1:0] REG_SPECIES  = 2'd2;
    localparam logic [1:0] REG_CUTOFF   = 2'd3;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_EMIT,
        ST_ROOT,
        ST_HOLD
    } snd_state_t;

    // Insertion request broadcast to every cell of one species row.
    typedef struct packed {
        logic        valid;
        logic [31:0] value;
    } snd_ins_t;
endpackage
`default_nettype wire

// File: design/snd_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel interfaces
// Input, output and configuration channels of the block.
// ----------------------------------------------------------------------------
`default_nettype none
interface snd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  neighbor_species;
    logic signed [31:0] distance_sq;
    logic        is_self;
    logic        no_neighbor;
    logic        last_neighbor;
    modport source (output valid, neighbor_species, distance_sq, is_self,
                    no_neighbor, last_neighbor, input ready);
    modport sink (input valid, neighbor_species, distance_sq, is_self,
                  no_neighbor, last_neighbor, output ready);
endinterface

interface snd_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] distance_out;
    logic [1:0]  species_slot;
    logic [3:0]  rank;
    logic        last_result;
    modport source (output valid, distance_out, species_slot, rank, last_result,
                    input ready);
    modport sink (input valid, distance_out, species_slot, rank, last_result,
                  output ready);
endinterface

interface snd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: design/snd_cell.sv
// ----------------------------------------------------------------------------
// Insertion sort cell
// Holds one kept distance; takes the new value, its left neighbor's value or shift_in.
// ----------------------------------------------------------------------------
`default_nettype none
module snd_cell
    import snd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire snd_ins_t    ins,
    input  wire logic        clear,
    input  wire logic        left_occ,
    input  wire logic        left_gt,
    input  wire logic [31:0] left_value,
    input  wire logic        shift_en,
    input  wire logic [31:0] shift_in,
    output logic             occ,
    output logic             gt,
    output logic [31:0]      value
);
    logic [31:0] value_reg;
    logic        occ_reg;
    logic [31:0] value_next;
    logic        occ_next;

    // A cell greater than the new value (or empty) yields: it takes the left
    // value if left also yields, else the new value.
    assign gt = !occ_reg || (value_reg > ins.value);

    always_comb
    begin
        value_next = value_reg;
        occ_next   = occ_reg;
        if (shift_en)
        begin
            value_next = shift_in;
        end
        else if (ins.valid && gt && left_occ)
        begin
            // left_occ is 1 for the first cell; empty cells past the fill take nothing.
            if (left_gt)
            begin
                value_next = left_value;
                occ_next   = 1'b1;
            end
            else
            begin
                value_next = ins.value;
                occ_next   = 1'b1;
            end
        end
        if (clear)
        begin
            occ_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign occ   = occ_reg;
    assign value = value_reg;
endmodule
`default_nettype wire

// File: design/snd_root.sv
// ----------------------------------------------------------------------------
// Iterative square root
// One result bit per cycle, floor(sqrt(v * 2^16)) truncated to 24 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module snd_root
    import snd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] value,
    output logic             done,
    output logic [23:0]      root
);
    logic [47:0] rem_reg, rem_next;
    logic [23:0] res_reg, res_next;
    logic [47:0] src_reg, src_next;
    logic [4:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [49:0] trial;
    logic [49:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        src_next  = src_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg, src_reg[47:46]};
        trial     = shifted - {24'd0, res_reg, 2'b01};
        if (start)
        begin
            rem_next  = '0;
            res_next  = '0;
            src_next  = {value, 16'd0};
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            src_next = {src_reg[45:0], 2'b00};
            if (!trial[49])
            begin
                rem_next = trial[47:0];
                res_next = {res_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[47:0];
                res_next = {res_reg[22:0], 1'b0};
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'd23)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        src_reg <= src_next;
    end

    assign done = busy_reg && (step_reg == 5'd23);
    assign root = res_next;
endmodule
`default_nettype wire

// File: design/sorted_neighbor_distances_core.sv
// ----------------------------------------------------------------------------
// Sorted neighbor distances core
// Keeps the nearest neighbor distances of one center and emits their roots.
// ----------------------------------------------------------------------------
// Usage: neighbor words enter on in_ch, results leave on out_ch and the four
// registers are written on cfg_ch (0 separate mode, 1 neighbors in use,
// 2 species in use, 3 cutoff). Each species has a row of MAX_KEPT insertion
// cells; every cell compares the new distance with its own and either keeps,
// takes the new value or takes its left neighbor's value, so a neighbor word
// is absorbed as it is taken, and the input accepts one word per cycle while
// collecting. On a word marked last the block stops taking input and walks
// the rows. Each kept distance goes through a bit-serial square root, one
// result bit at a time; padding results skip the root. After the final
// result is taken the cell counts are cleared and input reopens. While the
// receiver stalls, the result word holds and nothing advances. Reset
// empties all rows and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_neighbor_distances_core
    import snd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    snd_in_if.sink    in_ch,
    snd_out_if.source out_ch,
    snd_cfg_if.sink   cfg_ch
);
    logic        sep_reg;
    logic [4:0]  nbr_reg;
    logic [2:0]  spc_reg;
    logic [23:0] cut_reg;

    snd_state_t  state_reg, state_next;
    logic [1:0]  list_reg, list_next;
    logic [KEPT_W-1:0] rank_reg, rank_next;
    logic        ov_reg, ov_next;
    logic [23:0] dist_reg, dist_next;
    logic [1:0]  oslot_reg, oslot_next;
    logic [3:0]  orank_reg, orank_next;
    logic        olast_reg, olast_next;

    logic        clear;
    logic        root_start;
    logic        root_done;
    logic [23:0] root_val;

    snd_ins_t    ins [NUM_SPECIES];
    logic        occ [NUM_SPECIES][MAX_KEPT];
    logic        gtv [NUM_SPECIES][MAX_KEPT];
    logic [31:0] val [NUM_SPECIES][MAX_KEPT];

    logic        accept;
    logic [31:0] clamped;
    logic        do_ins;
    logic [4:0]  per;
    logic [2:0]  lists;
    logic        last_item;
    logic        cur_occ;
    logic        any_occ;
    logic [31:0] cur_val;

    assign accept  = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_COLLECT);
    assign clamped = in_ch.distance_sq[31] ? 32'd0 : in_ch.distance_sq;
    assign do_ins  = accept && !in_ch.is_self && !in_ch.no_neighbor;
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg <= 1'b0;
            nbr_reg <= 5'd16;
            spc_reg <= 3'd4;
            cut_reg <= 24'd327680;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_SEPARATE: sep_reg <= cfg_ch.data[0];
                REG_NEIGHBOR: nbr_reg <= cfg_ch.data[4:0];
                REG_SPECIES:  spc_reg <= cfg_ch.data[2:0];
                REG_CUTOFF:   cut_reg <= cfg_ch.data[23:0];
                default: ;
            endcase
        end
    end

    genvar s, k;
    generate
        for (s = 0; s < NUM_SPECIES; s++)
        begin : g_row
            assign ins[s].valid = do_ins &&
                (sep_reg ? (32'(in_ch.neighbor_species) == s) : (s == 0));
            assign ins[s].value = clamped;
            for (k = 0; k < MAX_KEPT; k++)
            begin : g_cell
                logic lo, lg;
                logic [31:0] lv;
                if (k == 0)
                begin : g_first
                    assign lo = 1'b1;
                    assign lg = 1'b0;
                    assign lv = '0;
                end
                else
                begin : g_next
                    assign lo = occ[s][k-1];
                    assign lg = gtv[s][k-1] && occ[s][k-1];
                    assign lv = val[s][k-1];
                end
                snd_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ins        (ins[s]),
                    .clear      (clear),
                    .left_occ   (lo),
                    .left_gt    (lg),
                    .left_value (lv),
                    .shift_en   (1'b0),
                    .shift_in   (32'd0),
                    .occ        (occ[s][k]),
                    .gt         (gtv[s][k]),
                    .value      (val[s][k])
                );
            end
        end
    endgenerate

    snd_root u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (cur_val),
        .done  (root_done),
        .root  (root_val)
    );

    assign per   = (nbr_reg == 5'd0) ? 5'd1 :
                   (nbr_reg > 5'(MAX_KEPT)) ? 5'(MAX_KEPT) : nbr_reg;
    assign lists = !sep_reg ? 3'd1 : (spc_reg == 3'd0) ? 3'd1 :
                   (spc_reg > 3'(NUM_SPECIES)) ? 3'(NUM_SPECIES) : spc_reg;
    assign cur_occ = occ[list_reg][rank_reg];
    assign any_occ = occ[list_reg][0];
    assign cur_val = val[list_reg][rank_reg];
    assign last_item = ({1'b0, rank_reg} == 5'(per - 5'd1)) &&
                       ({1'b0, list_reg} == 3'(lists - 3'd1));

    always_comb
    begin
        state_next = state_reg;
        list_next  = list_reg;
        rank_next  = rank_reg;
        ov_next    = ov_reg;
        dist_next  = dist_reg;
        oslot_next = oslot_reg;
        orank_next = orank_reg;
        olast_next = olast_reg;
        clear      = 1'b0;
        root_start = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                if (accept && in_ch.last_neighbor)
                begin
                    state_next = ST_EMIT;
                    list_next  = '0;
                    rank_next  = '0;
                end
            end
            ST_EMIT:
            begin
                oslot_next = list_reg;
                orank_next = 4'(rank_reg);
                olast_next = last_item;
                if (cur_occ)
                begin
                    root_start = 1'b1;
                    state_next = ST_ROOT;
                end
                else
                begin
                    dist_next  = any_occ ? cut_reg : 24'd0;
                    ov_next    = 1'b1;
                    state_next = ST_HOLD;
                end
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    dist_next  = root_val;
                    ov_next    = 1'b1;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_ch.ready)
                begin
                    ov_next = 1'b0;
                    if (olast_reg)
                    begin
                        clear      = 1'b1;
                        state_next = ST_COLLECT;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                        if ({1'b0, rank_reg} == 5'(per - 5'd1))
                        begin
                            rank_next = '0;
                            list_next = list_reg + 2'd1;
                        end
                        else
                        begin
                            rank_next = rank_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            list_reg  <= '0;
            rank_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            list_reg  <= list_next;
            rank_reg  <= rank_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg  <= dist_next;
        oslot_reg <= oslot_next;
        orank_reg <= orank_next;
        olast_reg <= olast_next;
    end

    assign out_ch.valid        = ov_reg;
    assign out_ch.distance_out = dist_reg;
    assign out_ch.species_slot = oslot_reg;
    assign out_ch.rank         = orank_reg;
    assign out_ch.last_result  = olast_reg;

`ifndef SYNTHESIS
    a_valid_only_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> state_reg == ST_HOLD) else $error("valid outside hold");
    a_no_input_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_COLLECT |-> !in_ch.ready) else $error("input open");
    a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
        clear |-> out_ch.last_result && out_ch.valid) else $error("bad clear");
`endif
endmodule
`default_nettype wire

// File: bench/snd_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted neighbor distance result checker
// Tracks register writes and neighbor words, keeps its own sorted lists and
// compares every result word with the predicted one.
// ----------------------------------------------------------------------------
module snd_result_checker
    import snd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    snd_in_if         in_ch,
    snd_out_if        out_ch,
    snd_cfg_if        cfg_ch,
    output int        error_count,
    output int        waiting_count
);
    typedef struct {
        logic [23:0] distance;
        logic [1:0]  slot;
        logic [3:0]  rank;
        logic        last;
    } distance_word_t;

    localparam int RESULT_CAP = 64;

    logic        sep_mode;
    logic [4:0]  per_list;
    logic [2:0]  list_total;
    logic [23:0] cutoff;
    logic [31:0] kept [NUM_SPECIES][MAX_KEPT];
    int          kept_cnt [NUM_SPECIES];
    distance_word_t expected_words [$];

    assign waiting_count = expected_words.size();

    // Truncated square root of v scaled to Q8.16, by trial bits.
    function automatic logic [23:0] q8_16_root(logic [31:0] v);
        logic [63:0] x;
        logic [63:0] trial;
        logic [23:0] r;
        x = {16'd0, v, 16'd0};
        r = '0;
        for (int b = 23; b >= 0; b--) begin
            trial = {40'd0, r | (24'd1 << b)};
            if (trial * trial <= x)
                r = trial[23:0];
        end
        return r;
    endfunction

    task automatic keep_distance(int row, logic [31:0] v);
        int p;
        if (kept_cnt[row] < MAX_KEPT) begin
            p = kept_cnt[row];
            kept_cnt[row]++;
        end
        else begin
            if (v >= kept[row][MAX_KEPT-1])
                return;
            p = MAX_KEPT - 1;
        end
        while (p > 0 && kept[row][p-1] > v) begin
            kept[row][p] = kept[row][p-1];
            p--;
        end
        kept[row][p] = v;
    endtask

    task automatic predict_center();
        int per;
        int rows;
        int n;
        distance_word_t w;
        per = (per_list < 1) ? 1 : (per_list > MAX_KEPT) ? MAX_KEPT : int'(per_list);
        rows = 1;
        if (sep_mode)
            rows = (list_total < 1) ? 1 : (list_total > NUM_SPECIES) ? NUM_SPECIES
                 : int'(list_total);
        n = 0;
        for (int l = 0; l < rows && n < RESULT_CAP; l++) begin
            for (int r = 0; r < per && n < RESULT_CAP; r++) begin
                if (r < kept_cnt[l])
                    w.distance = q8_16_root(kept[l][r]);
                else if (kept_cnt[l] > 0)
                    w.distance = cutoff;
                else
                    w.distance = '0;
                w.slot = l[1:0];
                w.rank = r[3:0];
                w.last = 1'b0;
                expected_words = {expected_words, w};
                n++;
            end
        end
        if (n > 0)
            expected_words[expected_words.size()-1].last = 1'b1;
        foreach (kept_cnt[i])
            kept_cnt[i] = 0;
    endtask

    always @(posedge clk or negedge rst_n) begin
        distance_word_t exp_w;
        logic [31:0] v;
        if (!rst_n) begin
            sep_mode    <= 1'b0;
            per_list    <= 5'd16;
            list_total  <= 3'd4;
            cutoff      <= 24'd327680;
            error_count <= 0;
            foreach (kept_cnt[i])
                kept_cnt[i] = 0;
            expected_words.delete();
        end
        else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_SEPARATE: sep_mode   <= cfg_ch.data[0];
                    REG_NEIGHBOR: per_list   <= cfg_ch.data[4:0];
                    REG_SPECIES:  list_total <= cfg_ch.data[2:0];
                    REG_CUTOFF:   cutoff     <= cfg_ch.data[23:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                if (!in_ch.is_self && !in_ch.no_neighbor) begin
                    v = in_ch.distance_sq[31] ? 32'd0 : in_ch.distance_sq;
                    keep_distance(sep_mode ? int'(in_ch.neighbor_species) : 0, v);
                end
                if (in_ch.last_neighbor)
                    predict_center();
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word: expected none, got %h/%0d/%0d/%0b",
                             $time, out_ch.distance_out, out_ch.species_slot,
                             out_ch.rank, out_ch.last_result);
                    error_count <= error_count + 1;
                end
                else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w.distance !== out_ch.distance_out || exp_w.slot !== out_ch.species_slot
                        || exp_w.rank !== out_ch.rank || exp_w.last !== out_ch.last_result) begin
                        $display("%0t: result word: expected %h/%0d/%0d/%0b, got %h/%0d/%0d/%0b",
                                 $time, exp_w.distance, exp_w.slot, exp_w.rank, exp_w.last,
                                 out_ch.distance_out, out_ch.species_slot, out_ch.rank,
                                 out_ch.last_result);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: bench/sorted_neighbor_distances_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted neighbor distances core test
// Drives neighbor lists under several register settings with random gaps and
// stalls; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module sorted_neighbor_distances_core_test;
    import snd_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 80;   // a little over three root computations

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycles = 0;
    int   error_count;
    int   waiting_count;
    int   words_sent = 0;
    bit   no_gaps = 1'b0;    // when set both sides run flat out

    snd_in_if  in_ch ();
    snd_out_if out_ch ();
    snd_cfg_if cfg_ch ();

    sorted_neighbor_distances_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    snd_result_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg_ch        (cfg_ch),
        .error_count   (error_count),
        .waiting_count (waiting_count)
    );

    always #5 clk = ~clk;

    // Guard against a hung handshake.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver stalls a random number of cycles before each result word,
    // except during stretches in which gaps are switched off.
    initial begin
        int w;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            w = no_gaps ? 0 : $urandom_range(0, 5);
            if (w > 0) begin
                out_ch.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // One neighbor word. Called at a rising edge; returns at the edge where
    // the word was taken, with valid still high.
    task automatic send_neighbor(logic [1:0] spec, logic [31:0] dsq,
                                 bit self_flag, bit empty_flag, bit last_flag);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.neighbor_species <= spec;
        in_ch.distance_sq      <= dsq;
        in_ch.is_self          <= self_flag;
        in_ch.no_neighbor      <= empty_flag;
        in_ch.last_neighbor    <= last_flag;
        do @(posedge clk); while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Registers change only once every predicted word has come out and the
    // root unit has had time to go quiet.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (waiting_count != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Squared distances: mostly small so that roots vary, with some at the
    // extremes and some negative values that must clamp to zero.
    function automatic logic [31:0] pick_distance();
        case ($urandom_range(0, 9))
            0:       return $urandom | 32'h8000_0000;
            1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2:       return $urandom_range(0, 3);
            3, 4:    return $urandom & 32'h7FFF_FFFF;
            default: return $urandom_range(0, 32'h00FF_FFFF);
        endcase
    endfunction

    // One center: a well-formed list of random length, occasionally with
    // self or empty entries, closed by a word marked last.
    task automatic send_center();
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 30) : $urandom_range(0, 12);
        for (int i = 0; i < len; i++)
            send_neighbor(2'($urandom), pick_distance(), $urandom_range(0, 15) == 0,
                          $urandom_range(0, 15) == 0, 1'b0);
        send_neighbor(2'($urandom), pick_distance(), $urandom_range(0, 3) == 0,
                      $urandom_range(0, 3) == 0, 1'b1);
    endtask

    initial begin
        int phase;
        in_ch.valid            = 1'b0;
        in_ch.neighbor_species = '0;
        in_ch.distance_sq      = '0;
        in_ch.is_self          = 1'b0;
        in_ch.no_neighbor      = 1'b0;
        in_ch.last_neighbor    = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = REG_SEPARATE;
        cfg_ch.data            = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings: an empty center, the
        // distance extremes, clamping, self and empty entries, and a full
        // list in which equal values are dropped.
        send_neighbor(2'd0, 32'd0, 1'b0, 1'b1, 1'b1);
        send_neighbor(2'd3, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_neighbor(2'd1, 32'h8000_0000, 1'b0, 1'b0, 1'b0);
        send_neighbor(2'd2, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_neighbor(2'd0, 32'd1, 1'b1, 1'b0, 1'b0);
        send_neighbor(2'd0, 32'h0001_0000, 1'b0, 1'b0, 1'b1);
        for (int i = 0; i < 18; i++)
            send_neighbor(2'(i), (i < 17) ? 32'h0004_0000 : 32'h0000_0001, 1'b0, 1'b0,
                          i == 17);
        settle();

        // Separate mode with out of range counts, the zero cutoff, and a
        // partial list left across the register change.
        write_register(REG_SEPARATE, 32'd1);
        write_register(REG_NEIGHBOR, 32'd31);
        write_register(REG_SPECIES, 32'd7);
        write_register(REG_CUTOFF, 32'd0);
        send_neighbor(2'd3, 32'h0010_0000, 1'b0, 1'b0, 1'b1);
        send_neighbor(2'd1, 32'h0000_4000, 1'b0, 1'b0, 1'b0);
        settle();
        write_register(REG_SEPARATE, 32'd0);
        send_neighbor(2'd2, 32'h0000_9000, 1'b0, 1'b0, 1'b0);
        settle();
        write_register(REG_SEPARATE, 32'd1);
        write_register(REG_NEIGHBOR, 32'd0);
        write_register(REG_SPECIES, 32'd0);
        write_register(REG_CUTOFF, 32'hFF_FFFF);
        send_neighbor(2'd0, 32'd5, 1'b0, 1'b0, 1'b1);
        settle();

        // Random part: a new setting per phase, extremes included.
        phase = 0;
        while (words_sent < 440) begin
            write_register(REG_SEPARATE, $urandom);
            case ($urandom_range(0, 3))
                0:       write_register(REG_NEIGHBOR, 32'd1);
                1:       write_register(REG_NEIGHBOR, 32'd16);
                default: write_register(REG_NEIGHBOR, $urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       write_register(REG_SPECIES, 32'd1);
                1:       write_register(REG_SPECIES, 32'd4);
                default: write_register(REG_SPECIES, $urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       write_register(REG_CUTOFF, 32'd0);
                1:       write_register(REG_CUTOFF, 32'hFF_FFFF);
                default: write_register(REG_CUTOFF, $urandom);
            endcase
            no_gaps = (phase % 4 == 3);
            repeat ($urandom_range(2, 6))
                send_center();
            // Now and then leave a list open so the next setting sees it.
            if ($urandom_range(0, 3) == 0)
                send_neighbor(2'($urandom), pick_distance(), 1'b0, 1'b0, 1'b0);
            settle();
            phase++;
        end
        no_gaps = 1'b0;
        send_center();
        settle();

        if (error_count == 0 && waiting_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: files.f
design/snd_pkg.sv
design/snd_if.sv
design/snd_cell.sv
design/snd_root.sv
design/sorted_neighbor_distances_core.sv
bench/snd_result_checker.sv
bench/sorted_neighbor_distances_core_test.sv
